/* rtl/core/s2a_pkg.sv */
// ----------------------------------------------------------------------------
// s2a_pkg
// Shared types, key codes and keymap tables for the set-1 scancode decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package s2a_pkg;

    // key codes of interest
    localparam logic [7:0] KEY_SHIFT_L     = 8'h2a;
    localparam logic [7:0] KEY_SHIFT_R     = 8'h36;
    localparam logic [7:0] KEY_CAPS        = 8'h3a;
    localparam logic [7:0] KEY_TAB         = 8'h0f;
    localparam logic [7:0] KEY_REL_SHIFT_L = 8'haa;
    localparam logic [7:0] KEY_REL_SHIFT_R = 8'hb6;

    localparam int unsigned MAP_LEN = 86;
    localparam int unsigned MAP_IW  = $clog2(MAP_LEN);

    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam int unsigned TAB_BEATS = 4;
    localparam int unsigned REM_W = $clog2(TAB_BEATS);

    // one decoded command travelling from front to back
    typedef struct packed {
        logic [6:0] ch;
        logic       tab;
    } t_cmd;

    // queue status seen by front and back
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    // unshifted keymap
    localparam logic [6:0] BASE_MAP [0:MAP_LEN-1] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, // 0
        7'h39, 7'h30, 7'h2d, 7'h3d, 7'h00, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72, // 10
        7'h74, 7'h79, 7'h75, 7'h69, 7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h0a, 7'h00, // 20
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6a, 7'h6b, 7'h6c, 7'h3b, // 30
        7'h27, 7'h60, 7'h00, 7'h5c, 7'h7a, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6e, // 40
        7'h6d, 7'h2c, 7'h2e, 7'h2f, 7'h00, 7'h2a, 7'h00, 7'h20, 7'h00, 7'h00, // 50
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, // 60
        7'h00, 7'h37, 7'h38, 7'h39, 7'h2d, 7'h34, 7'h35, 7'h36, 7'h2b, 7'h31, // 70
        7'h32, 7'h33, 7'h30, 7'h2e, 7'h00, 7'h00                              // 80
    };

    // shifted keymap
    localparam logic [6:0] SHIFT_MAP [0:MAP_LEN-1] = '{
        7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e, 7'h26, 7'h2a, // 0
        7'h28, 7'h29, 7'h5f, 7'h2b, 7'h00, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52, // 10
        7'h54, 7'h59, 7'h55, 7'h49, 7'h4f, 7'h50, 7'h7b, 7'h7d, 7'h0a, 7'h00, // 20
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4a, 7'h4b, 7'h4c, 7'h3a, // 30
        7'h22, 7'h7e, 7'h00, 7'h7c, 7'h5a, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4e, // 40
        7'h4d, 7'h3c, 7'h3e, 7'h3f, 7'h00, 7'h2a, 7'h00, 7'h20, 7'h00, 7'h00, // 50
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, // 60
        7'h00, 7'h37, 7'h38, 7'h39, 7'h2d, 7'h34, 7'h35, 7'h36, 7'h2b, 7'h31, // 70
        7'h32, 7'h33, 7'h30, 7'h2e, 7'h00, 7'h00                              // 80
    };

    // ascii letter test
    function automatic logic is_letter(input logic [6:0] c);
        return ((c >= 7'h61) && (c <= 7'h7a)) || ((c >= 7'h41) && (c <= 7'h5a));
    endfunction

endpackage

`default_nettype wire

/* rtl/core/s2a_front.sv */
// ----------------------------------------------------------------------------
// s2a_front
// Accepts scancode beats, tracks shift and caps state, and pushes one
// command per character-producing press into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module s2a_front
    import s2a_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_scancode,
    input  wire t_q_stat    i_q_stat,
    output logic            o_push,
    output t_cmd            o_cmd
);

    logic [7:0]        r_shift_count;
    logic [7:0]        n_shift_count;
    logic              r_caps;
    logic              n_caps;
    logic              accept;
    logic              is_press;
    logic              in_map;
    logic [MAP_IW-1:0] map_idx;
    logic [6:0]        base_ch;
    logic [6:0]        pick_ch;
    logic [6:0]        final_ch;

    // one beat per cycle unless the queue is full
    assign o_stall  = i_q_stat.full;
    assign accept   = i_valid && !o_stall;
    assign is_press = !i_scancode[7];

    // keymap lookup
    assign in_map   = is_press && (i_scancode[6:0] < 7'(MAP_LEN));
    assign map_idx  = in_map ? i_scancode[MAP_IW-1:0] : '0;
    assign base_ch  = BASE_MAP[map_idx];
    assign pick_ch  = (r_shift_count != 8'd0) ? SHIFT_MAP[map_idx] : base_ch;
    assign final_ch = (r_caps && is_letter(pick_ch)) ? (pick_ch ^ 7'h20) : pick_ch;

    // classify the beat
    always_comb begin
        n_shift_count = r_shift_count;
        n_caps        = r_caps;
        o_push        = 1'b0;
        o_cmd.ch      = final_ch;
        o_cmd.tab     = 1'b0;
        if (accept) begin
            if (!is_press) begin
                if ((i_scancode == KEY_REL_SHIFT_L) || (i_scancode == KEY_REL_SHIFT_R)) begin
                    n_shift_count = r_shift_count - 8'd1;
                end
            end else if ((i_scancode == KEY_SHIFT_L) || (i_scancode == KEY_SHIFT_R)) begin
                n_shift_count = r_shift_count + 8'd1;
            end else if (i_scancode == KEY_CAPS) begin
                n_caps = !r_caps;
            end else if (i_scancode == KEY_TAB) begin
                o_push    = 1'b1;
                o_cmd.ch  = CH_SPACE;
                o_cmd.tab = 1'b1;
            end else if (in_map && (base_ch != 7'd0)) begin
                o_push = 1'b1;
            end
        end
    end

    // modifier state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_count <= 8'd0;
            r_caps        <= 1'b0;
        end else begin
            r_shift_count <= n_shift_count;
            r_caps        <= n_caps;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/s2a_queue.sv */
// ----------------------------------------------------------------------------
// s2a_queue
// Small command queue between the decode front and the character back end.
// ----------------------------------------------------------------------------
`default_nettype none

module s2a_queue
    import s2a_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_cmd    i_cmd,
    input  wire logic    i_pop,
    output t_cmd         o_cmd,
    output t_q_stat      o_stat
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [0:DEPTH-1];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW-1:0] n_rd_ptr;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          do_push;
    logic          do_pop;

    assign o_stat.empty = (r_count == CW'(0));
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_cmd        = r_mem[r_rd_ptr];
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/s2a_back.sv */
// ----------------------------------------------------------------------------
// s2a_back
// Pops commands and drives character beats through an output register,
// repeating the space four times for a tab.
// ----------------------------------------------------------------------------
`default_nettype none

module s2a_back
    import s2a_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_q_stat i_q_stat,
    input  wire t_cmd    i_cmd,
    output logic         o_pop,
    output logic         o_valid,
    input  wire logic    i_stall,
    output logic [6:0]   o_character,
    output logic         o_last_of_run
);

    logic             r_valid;
    logic             n_valid;
    logic [6:0]       r_char;
    logic [6:0]       n_char;
    logic             r_last;
    logic             n_last;
    logic [REM_W-1:0] r_rem;
    logic [REM_W-1:0] n_rem;
    logic             out_free;

    assign out_free      = !r_valid || !i_stall;
    assign o_valid       = r_valid;
    assign o_character   = r_char;
    assign o_last_of_run = r_last;

    // beat sequencing
    always_comb begin
        n_valid = r_valid && i_stall;
        n_char  = r_char;
        n_last  = r_last;
        n_rem   = r_rem;
        o_pop   = 1'b0;
        if (out_free) begin
            if (r_rem != '0) begin
                n_valid = 1'b1;
                n_char  = CH_SPACE;
                n_last  = (r_rem == REM_W'(1));
                n_rem   = r_rem - REM_W'(1);
            end else if (!i_q_stat.empty) begin
                o_pop   = 1'b1;
                n_valid = 1'b1;
                n_char  = i_cmd.ch;
                n_last  = !i_cmd.tab;
                n_rem   = i_cmd.tab ? REM_W'(TAB_BEATS - 1) : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rem   <= '0;
        end else begin
            r_valid <= n_valid;
            r_rem   <= n_rem;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_last <= n_last;
    end

endmodule

`default_nettype wire

/* rtl/core/scancode_to_ascii_decoder.sv */
// ----------------------------------------------------------------------------
// scancode_to_ascii_decoder
// Set-1 keyboard scancode to ASCII decoder with shift and caps-lock handling.
// ----------------------------------------------------------------------------
// The front end takes one scancode beat per clock while its command queue has
// room, updating the shift count and caps flag in the same cycle. The back end
// sends one character beat per clock from a registered output stage while the
// sink does not stall: a normal press yields one beat, a tab press four spaces,
// and modifiers, releases and unmapped keys yield none. Sustained throughput is
// set by the output port at one character per cycle when not stalled; a beat
// passes through the command queue and then the output register before the
// sink can take it.
`default_nettype none

module scancode_to_ascii_decoder
    import s2a_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_scancode,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [6:0]      o_character,
    output logic            o_last_of_run
);

    t_q_stat q_stat;
    t_cmd    push_cmd;
    t_cmd    head_cmd;
    logic    push;
    logic    pop;

    // decode front
    s2a_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_scancode (i_scancode),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    // command queue
    s2a_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_stat  (q_stat)
    );

    // character back end
    s2a_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_stat      (q_stat),
        .i_cmd         (head_cmd),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_character   (o_character),
        .o_last_of_run (o_last_of_run)
    );

`ifndef SYNTH
    // no push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && q_stat.full))
        else $error("push into full command queue");

    // only a tab run has beats that are not last, and those are spaces
    a_run_is_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_of_run) |-> (o_character == CH_SPACE))
        else $error("non-final beat is not a space");

    // a run continues without a gap once a non-final beat is taken
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_of_run) |=> o_valid)
        else $error("tab run broken");

    // pop only when a command is waiting
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty command queue");
`endif

endmodule

`default_nettype wire
